[src/asl_pkg.sv]
package asl_pkg;

  localparam int unsigned AVG_COUNT_DEF     = 50;
  localparam int unsigned QUANT_BITS_DEF    = 3;
  localparam int unsigned ERROR_LIMIT_DEF   = 100;
  localparam int unsigned INVERT_TARGET_DEF = 0;

  localparam int unsigned MUL_AW = 28;
  localparam int unsigned MUL_BW = 16;
  localparam int unsigned MUL_PW = 44;
  localparam int unsigned DIV_NW = 42;
  localparam int unsigned DIV_DW = 15;

  localparam logic [14:0] FILT_DEN  = 15'd24001;
  localparam logic [15:0] FILT_NUM  = 16'd23999;
  localparam logic [10:0] NAV_SCALE = 11'd1485;
  localparam logic [1:0]  STATUS_OK = 2'b11;

  typedef enum logic [2:0] {
    REG_AXIS_LABEL,
    REG_INPUT_LIMIT,
    REG_PWM_MIN,
    REG_PWM_MAX,
    REG_PWM_GAIN,
    REG_PWM_OFFSET,
    REG_SENSOR_OFFSET,
    REG_SENSOR_GAIN
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMUL,
    S_FMUL_W,
    S_FDIV,
    S_FDIV_W,
    S_PMUL,
    S_PMUL_W,
    S_SMUL,
    S_SMUL_W,
    S_ADIV,
    S_ADIV_W,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [9:0]  encoder_sample;
    logic [31:0] nav_word;
  } in_t;

  typedef struct packed {
    logic [13:0]        pwm_code;
    logic signed [23:0] feedback_angle;
  } out_t;

endpackage

[src/attitude_servo_loop_core.sv]
// Navigation word: taken while idle, no result; one may follow every cycle.
// Control tick: bit-serial passes run in turn, filter multiply, filter divide, PWM multiply,
// sensor multiply and, when the tick closes an averaging block, average divide (three
// multiplier passes, one or two divider passes). The next item is taken the cycle after
// the result is loaded, later while an earlier result still waits on the output.
// Asynchronous active-low reset restores register defaults and clears all loop state.
module attitude_servo_loop_core #(
  parameter int unsigned AVG_COUNT     = asl_pkg::AVG_COUNT_DEF,
  parameter int unsigned QUANT_BITS    = asl_pkg::QUANT_BITS_DEF,
  parameter int unsigned ERROR_LIMIT   = asl_pkg::ERROR_LIMIT_DEF,
  parameter int unsigned INVERT_TARGET = asl_pkg::INVERT_TARGET_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  asl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output asl_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned PW = asl_pkg::MUL_PW;
  localparam int unsigned NW = asl_pkg::DIV_NW;
  localparam logic signed [29:0] ELIM = 30'(ERROR_LIMIT * 65536);
  localparam logic [13:0] QMASK = ~((14'd1 << QUANT_BITS) - 14'd1);
  localparam logic [9:0]  AVG_N = 10'(AVG_COUNT);

  asl_pkg::state_e state_q, state_d;

  logic [7:0]  label_q, label_d;
  logic [6:0]  ilim_q, ilim_d;
  logic [13:0] pmin_q, pmin_d, pmax_q, pmax_d, poff_q, poff_d;
  logic [9:0]  pgain_q, pgain_d, soff_q, soff_d;
  logic [15:0] sgain_q, sgain_d;

  logic signed [23:0] target_q, target_d, fb_q, fb_d;
  logic signed [26:0] perr_q, perr_d, err_q, err_d;
  logic signed [27:0] py_q, py_d;
  logic signed [31:0] sum_q, sum_d;
  logic [9:0]         cnt_q, cnt_d, sample_q, sample_d;
  logic signed [PW-1:0] num_q, num_d;
  logic [13:0]        code_q, code_d;
  logic               out_valid_q, out_valid_d;
  asl_pkg::out_t      out_q, out_d;

  logic                          mul_start, mul_done;
  logic signed [asl_pkg::MUL_AW-1:0] mul_a;
  logic [asl_pkg::MUL_BW-1:0]    mul_b;
  logic signed [PW-1:0]          mul_p;
  logic                          div_start, div_done;
  logic [NW-1:0]                 div_n, div_q;
  logic [asl_pkg::DIV_DW-1:0]    div_d;

  logic signed [18:0] nav_raw;
  logic signed [30:0] nav_deg;
  logic signed [25:0] nav_fl, nav_lim;
  logic signed [24:0] diff;
  logic signed [29:0] err_w;
  logic signed [PW-1:0] mag, t;
  logic signed [27:0] code_w;
  logic signed [10:0] sdiff;
  logic signed [PW-1:0] sum_w;
  logic [9:0]         cnt_w;
  logic [32:0]        sum_mag;
  logic signed [NW:0] avg_w;

  asl_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  asl_serdiv u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .q_o    (div_q)
  );

  always_comb begin
    state_d     = state_q;
    label_d     = label_q;
    ilim_d      = ilim_q;
    pmin_d      = pmin_q;
    pmax_d      = pmax_q;
    pgain_d     = pgain_q;
    poff_d      = poff_q;
    soff_d      = soff_q;
    sgain_d     = sgain_q;
    target_d    = target_q;
    fb_d        = fb_q;
    perr_d      = perr_q;
    err_d       = err_q;
    py_d        = py_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    sample_d    = sample_q;
    num_d       = num_q;
    code_d      = code_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mul_start   = 1'b0;
    mul_a       = py_q;
    mul_b       = asl_pkg::FILT_NUM;
    div_start   = 1'b0;
    div_n       = '0;
    div_d       = asl_pkg::FILT_DEN;

    nav_raw = $signed(in_data_i.nav_word[28:10]);
    nav_deg = 31'(nav_raw) * $signed({1'b0, asl_pkg::NAV_SCALE});
    if (INVERT_TARGET != 0) begin
      nav_deg = -nav_deg;
    end
    nav_fl  = 26'(nav_deg >>> 5);
    nav_lim = $signed({3'b000, ilim_q, 16'h0000});

    diff  = 25'(target_q) - 25'(fb_q);
    err_w = 30'(diff) <<< 5;
    if (err_w > ELIM) begin
      err_w = ELIM;
    end else if (err_w < -ELIM) begin
      err_w = -ELIM;
    end

    mag = num_q[PW-1] ? -num_q : num_q;

    t = mul_p + PW'($signed({1'b0, poff_q, 16'h0000}));
    if (t[PW-1]) begin
      t = t + PW'(65535);
    end
    code_w = 28'(t >>> 16);
    if (code_w > $signed({14'd0, pmax_q})) begin
      code_w = $signed({14'd0, pmax_q});
    end
    if (code_w < $signed({14'd0, pmin_q})) begin
      code_w = $signed({14'd0, pmin_q});
    end

    sdiff = $signed({1'b0, sample_q}) - $signed({1'b0, soff_q});
    sum_w = PW'(sum_q) + mul_p;
    if (sum_w > PW'(32'sh7FFF_FFFF)) begin
      sum_w = PW'(32'sh7FFF_FFFF);
    end else if (sum_w < -PW'(33'sh0_8000_0000)) begin
      sum_w = -PW'(33'sh0_8000_0000);
    end
    cnt_w = cnt_q + 10'd1;

    sum_mag = sum_q[31] ? -33'(sum_q) : 33'(sum_q);
    avg_w   = sum_q[31] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (avg_w > (NW+1)'(24'sh7F_FFFF)) begin
      avg_w = (NW+1)'(24'sh7F_FFFF);
    end else if (avg_w < (NW+1)'(-25'sh80_0000)) begin
      avg_w = (NW+1)'(-25'sh80_0000);
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      asl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.kind) begin
            if (in_data_i.nav_word[7:0] == label_q &&
                in_data_i.nav_word[30:29] == asl_pkg::STATUS_OK) begin
              if (nav_fl > nav_lim) begin
                target_d = 24'(nav_lim);
              end else if (nav_fl < -nav_lim) begin
                target_d = 24'(-nav_lim);
              end else begin
                target_d = 24'(nav_fl);
              end
            end
          end else begin
            sample_d = in_data_i.encoder_sample;
            err_d    = 27'(err_w);
            state_d  = asl_pkg::S_FMUL;
          end
        end
      end
      asl_pkg::S_FMUL: begin
        mul_start = 1'b1;
        state_d   = asl_pkg::S_FMUL_W;
      end
      asl_pkg::S_FMUL_W: begin
        if (mul_done) begin
          num_d   = PW'(err_q) + PW'(perr_q) + mul_p;
          state_d = asl_pkg::S_FDIV;
        end
      end
      asl_pkg::S_FDIV: begin
        div_start = 1'b1;
        div_n     = mag[NW-1:0];
        state_d   = asl_pkg::S_FDIV_W;
      end
      asl_pkg::S_FDIV_W: begin
        if (div_done) begin
          py_d    = num_q[PW-1] ? -$signed(div_q[27:0]) : $signed(div_q[27:0]);
          perr_d  = err_q;
          state_d = asl_pkg::S_PMUL;
        end
      end
      asl_pkg::S_PMUL: begin
        mul_start = 1'b1;
        mul_b     = {6'd0, pgain_q};
        state_d   = asl_pkg::S_PMUL_W;
      end
      asl_pkg::S_PMUL_W: begin
        if (mul_done) begin
          code_d  = code_w[13:0] & QMASK;
          state_d = asl_pkg::S_SMUL;
        end
      end
      asl_pkg::S_SMUL: begin
        mul_start = 1'b1;
        mul_a     = 28'(sdiff);
        mul_b     = sgain_q;
        state_d   = asl_pkg::S_SMUL_W;
      end
      asl_pkg::S_SMUL_W: begin
        if (mul_done) begin
          sum_d = 32'(sum_w);
          cnt_d = cnt_w;
          if (cnt_w >= AVG_N) begin
            state_d = asl_pkg::S_ADIV;
          end else begin
            state_d = asl_pkg::S_OUT;
          end
        end
      end
      asl_pkg::S_ADIV: begin
        div_start = 1'b1;
        div_n     = NW'(sum_mag);
        div_d     = asl_pkg::DIV_DW'(AVG_COUNT);
        state_d   = asl_pkg::S_ADIV_W;
      end
      asl_pkg::S_ADIV_W: begin
        if (div_done) begin
          fb_d    = 24'(avg_w);
          sum_d   = '0;
          cnt_d   = '0;
          state_d = asl_pkg::S_OUT;
        end
      end
      asl_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.pwm_code       = code_q;
          out_d.feedback_angle = fb_q;
          state_d              = asl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = asl_pkg::S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (asl_pkg::reg_idx_e'(cfg_idx_i))
        asl_pkg::REG_AXIS_LABEL:    label_d = cfg_data_i[7:0];
        asl_pkg::REG_INPUT_LIMIT:   ilim_d  = cfg_data_i[6:0];
        asl_pkg::REG_PWM_MIN:       pmin_d  = cfg_data_i[13:0];
        asl_pkg::REG_PWM_MAX:       pmax_d  = cfg_data_i[13:0];
        asl_pkg::REG_PWM_GAIN:      pgain_d = cfg_data_i[9:0];
        asl_pkg::REG_PWM_OFFSET:    poff_d  = cfg_data_i[13:0];
        asl_pkg::REG_SENSOR_OFFSET: soff_d  = cfg_data_i[9:0];
        asl_pkg::REG_SENSOR_GAIN:   sgain_d = cfg_data_i;
        default:                    label_d = label_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asl_pkg::S_IDLE;
      label_q     <= 8'd212;
      ilim_q      <= 7'd5;
      pmin_q      <= 14'd5150;
      pmax_q      <= 14'd8850;
      pgain_q     <= 10'd368;
      poff_q      <= 14'd7000;
      soff_q      <= 10'd347;
      sgain_q     <= 16'd2018;
      target_q    <= '0;
      fb_q        <= '0;
      perr_q      <= '0;
      py_q        <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      label_q     <= label_d;
      ilim_q      <= ilim_d;
      pmin_q      <= pmin_d;
      pmax_q      <= pmax_d;
      pgain_q     <= pgain_d;
      poff_q      <= poff_d;
      soff_q      <= soff_d;
      sgain_q     <= sgain_d;
      target_q    <= target_d;
      fb_q        <= fb_d;
      perr_q      <= perr_d;
      py_q        <= py_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q    <= err_d;
    sample_q <= sample_d;
    num_q    <= num_d;
    code_q   <= code_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/asl_sermul.sv]
module asl_sermul #(
  parameter int unsigned AW = asl_pkg::MUL_AW,
  parameter int unsigned BW = asl_pkg::MUL_BW,
  parameter int unsigned PW = asl_pkg::MUL_PW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic        [BW-1:0] b_i,
  output logic                 done_o,
  output logic signed [PW-1:0] p_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] acc_q, acc_d, a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic          done_q, done_d;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      acc_d = '0;
      a_d   = PW'(a_i);
      b_d   = b_i;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(BW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = $signed(acc_q);

endmodule

[src/asl_serdiv.sv]
module asl_serdiv #(
  parameter int unsigned NW = asl_pkg::DIV_NW,
  parameter int unsigned DW = asl_pkg::DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [NW-1:0] q_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_q, n_d;
  logic [DW-1:0] d_q, d_d, rem_q, rem_d;
  logic [DW:0]   trial;
  logic          done_q, done_d;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    d_d    = d_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = {rem_q, n_q[NW-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      n_d   = n_i;
      d_d   = d_i;
      rem_d = '0;
    end else if (run_q) begin
      if (trial >= {1'b0, d_q}) begin
        rem_d = DW'(trial - {1'b0, d_q});
        n_d   = {n_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        n_d   = {n_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign q_o    = n_q;

endmodule

[bench/attitude_servo_checker.sv]
module attitude_servo_checker
  import asl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  in_t   in_data_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  out_t  out_data_i,
  input  logic  cfg_we_i,
  input  logic  [2:0] cfg_idx_i,
  input  logic  [15:0] cfg_data_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    ticks_o,
  output int    navs_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_DEG = 65536;

  logic [7:0]  label_q;
  logic [6:0]  in_lim_q;
  logic [13:0] pmin_q, pmax_q, poff_q;
  logic [9:0]  pgain_q, soff_q;
  logic [15:0] sgain_q;

  longint target_q, prev_err_q, prev_filt_q, fb_q, sum_q;
  int     count_q;
  out_t   expected_pwm_q[$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic decode_nav(logic [31:0] w);
    longint raw, deg, lim;
    if (w[7:0] != label_q || w[30:29] != STATUS_OK) return;
    raw = longint'(signed'(w[28:10]));
    deg = raw * 45;
    if (INVERT_TARGET_DEF != 0) deg = -deg;
    deg = (deg * 33) >>> 5;
    lim = longint'(in_lim_q) * ONE_DEG;
    target_q = clamp(deg, -lim, lim);
  endtask

  task automatic servo_tick(logic [9:0] enc);
    longint elim, err, y, code, pos;
    out_t   r;
    elim = longint'(ERROR_LIMIT_DEF) * ONE_DEG;
    err = clamp((target_q - fb_q) * 32, -elim, elim);
    y = (err + prev_err_q + 64'sd23999 * prev_filt_q) / 64'sd24001;
    prev_err_q = err;
    prev_filt_q = y;
    code = (y * longint'(pgain_q) + longint'(poff_q) * ONE_DEG) / ONE_DEG;
    if (code > longint'(pmax_q)) code = pmax_q;
    if (code < longint'(pmin_q)) code = pmin_q;
    code = (code >> QUANT_BITS_DEF) << QUANT_BITS_DEF;
    pos = (longint'(enc) - longint'(soff_q)) * longint'(sgain_q);
    sum_q = clamp(sum_q + pos, -64'sd2147483648, 64'sd2147483647);
    count_q = (count_q + 1) & 10'h3FF;
    if (count_q >= AVG_COUNT_DEF) begin
      fb_q = clamp(sum_q / longint'(AVG_COUNT_DEF), -64'sd8388608, 64'sd8388607);
      sum_q = 0;
      count_q = 0;
    end
    r.pwm_code = code[13:0];
    r.feedback_angle = fb_q[23:0];
    expected_pwm_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      label_q <= 8'd212; in_lim_q <= 7'd5; pmin_q <= 14'd5150; pmax_q <= 14'd8850;
      pgain_q <= 10'd368; poff_q <= 14'd7000; soff_q <= 10'd347; sgain_q <= 16'd2018;
      target_q = 0; prev_err_q = 0; prev_filt_q = 0; fb_q = 0; sum_q = 0; count_q = 0;
      expected_pwm_q.delete();
      fail_count_o = 0; ticks_o = 0; navs_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind) begin
          decode_nav(in_data_i.nav_word);
          navs_o++;
        end else begin
          servo_tick(in_data_i.encoder_sample);
          ticks_o++;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pwm_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result pwm=%0d fb=%0d", $realtime,
                     out_data_i.pwm_code, out_data_i.feedback_angle);
        end else begin
          want = expected_pwm_q.pop_front();
          if (want.pwm_code !== out_data_i.pwm_code ||
              want.feedback_angle !== out_data_i.feedback_angle) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch pwm exp %0d got %0d, fb exp %0d got %0d", $realtime,
                       want.pwm_code, out_data_i.pwm_code,
                       want.feedback_angle, out_data_i.feedback_angle);
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_AXIS_LABEL:    label_q  <= cfg_data_i[7:0];
          REG_INPUT_LIMIT:   in_lim_q <= cfg_data_i[6:0];
          REG_PWM_MIN:       pmin_q   <= cfg_data_i[13:0];
          REG_PWM_MAX:       pmax_q   <= cfg_data_i[13:0];
          REG_PWM_GAIN:      pgain_q  <= cfg_data_i[9:0];
          REG_PWM_OFFSET:    poff_q   <= cfg_data_i[13:0];
          REG_SENSOR_OFFSET: soff_q   <= cfg_data_i[9:0];
          REG_SENSOR_GAIN:   sgain_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_pwm_q.size();
  end
endmodule

[bench/testbench.sv]
module testbench;
  import asl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 150;
  localparam int WATCH_LIMIT = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int   fails, pending, ticks, navs;
  bit   no_idle = 1'b0;
  logic [7:0] cur_label = 8'd212;
  int   idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  attitude_servo_loop_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  attitude_servo_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending), .ticks_o(ticks), .navs_o(navs)
  );

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(negedge clk_i);
      while (!out_valid) @(negedge clk_i);
      @(posedge clk_i);
    end
  end

  task automatic transfer(in_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic tick(logic [9:0] enc);
    in_t d;
    d.kind = 1'b0;
    d.encoder_sample = enc;
    d.nav_word = $urandom;
    transfer(d);
  endtask

  task automatic nav(logic [7:0] label, logic [1:0] status, logic [18:0] angle);
    in_t d;
    d.kind = 1'b1;
    d.encoder_sample = 10'($urandom);
    d.nav_word = $urandom;
    d.nav_word[7:0] = label;
    d.nav_word[30:29] = status;
    d.nav_word[28:10] = angle;
    transfer(d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_label = v[REG_AXIS_LABEL][7:0];
  endtask

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) tick(10'($urandom));
      else if (r < 90) nav(cur_label, STATUS_OK, 19'($urandom));
      else if (r < 95) nav(cur_label, 2'($urandom), 19'($urandom));
      else nav(8'($urandom), 2'($urandom), 19'($urandom));
    end
  endtask

  initial begin
    logic [15:0] v[8];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick(10'd0);
    tick(10'd1023);
    nav(cur_label, STATUS_OK, 19'h40000);
    tick(10'd347);
    tick(10'd0);
    nav(cur_label, STATUS_OK, 19'h3FFFF);
    tick(10'd1023);
    nav(cur_label, 2'b01, 19'h40000);
    nav(cur_label, 2'b10, 19'h40000);
    nav(cur_label, 2'b00, 19'h40000);
    nav(~cur_label, STATUS_OK, 19'h40000);
    tick(10'd512);
    nav(cur_label, STATUS_OK, 19'h00000);
    nav(cur_label, STATUS_OK, 19'h00001);
    nav(cur_label, STATUS_OK, 19'h7FFFF);
    tick(10'd1);
    nav(cur_label, STATUS_OK, 19'h2AAAA);
    nav(cur_label, STATUS_OK, 19'h55555);
    for (int i = 0; i < 5; i++) tick(10'h3FF);
    random_items(120);
    drain();
    random_items(130);
    drain();

    v = '{16'd255, 16'd90, 16'd16383, 16'd16383, 16'd1023, 16'd16383, 16'd1023, 16'd65535};
    configure(v);
    no_idle = 1'b1;
    random_items(150);
    drain();

    v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    configure(v);
    no_idle = 1'b0;
    random_items(150);
    drain();

    v = '{16'd212, 16'd45, 16'd9000, 16'd4000, 16'd500, 16'd7000, 16'd512, 16'd40000};
    configure(v);
    random_items(150);
    drain();

    for (int p = 0; p < 5; p++) begin
      v[REG_AXIS_LABEL] = 16'($urandom_range(0, 255));
      v[REG_INPUT_LIMIT] = 16'($urandom_range(0, 90));
      v[REG_PWM_MIN] = 16'($urandom_range(0, 8000));
      v[REG_PWM_MAX] = 16'($urandom_range(6000, 16383));
      v[REG_PWM_GAIN] = 16'($urandom_range(0, 1023));
      v[REG_PWM_OFFSET] = 16'($urandom_range(0, 16383));
      v[REG_SENSOR_OFFSET] = 16'($urandom_range(0, 1023));
      v[REG_SENSOR_GAIN] = 16'($urandom_range(0, 65535));
      configure(v);
      no_idle = p[0];
      random_items(185);
      drain();
    end

    $display("Covered %0d control ticks and %0d navigation words", ticks, navs);
    $display("over nine register settings, extremes and crossed PWM clamps included");
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
src/asl_pkg.sv
src/asl_sermul.sv
src/asl_serdiv.sv
src/attitude_servo_loop_core.sv
bench/attitude_servo_checker.sv
bench/testbench.sv
